[hw/rtl/cir_pkg.sv]
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types, status codes and helpers for the collision impulse resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package cir_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_COIN = 2'd1;
    localparam status_t ST_SAT  = 2'd2;

    localparam int GSHIFT = 13;
    localparam int ESHIFT = 17;
    localparam int WSHIFT = 28;

    typedef struct packed {
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
    } vel_t;

    typedef struct packed {
        logic        coin;
        logic        negp;
        logic        dxneg;
        logic        dyneg;
        logic [15:0] ux;
        logic [15:0] uy;
        logic [17:0] q;
        vel_t        vel;
    } side_t;

    // Add a signed delta to a velocity and clamp; bit 32 flags saturation.
    function automatic logic [32:0] sat_apply(logic signed [31:0] v, logic neg,
                                              logic [36:0] m);
        logic signed [38:0] s;
        logic [32:0]        r;
        s = neg ? 39'(v) - $signed({2'b00, m}) : 39'(v) + $signed({2'b00, m});
        if (s > 39'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end
        else if (s < -39'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end
        else begin
            r = {1'b0, s[31:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cir_in_if.sv]
// ----------------------------------------------------------------------------
// cir_in_if
// Input channel: one colliding pair of bodies per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cir_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
    logic [15:0]        elast_a;
    logic [15:0]        elast_b;

    modport source (
        output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
               vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b, elast_a, elast_b,
        input  ready
    );

    modport sink (
        input  valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
               vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b, elast_a, elast_b,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/cir_out_if.sv]
// ----------------------------------------------------------------------------
// cir_out_if
// Output channel: resolved velocities and status per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cir_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    cir_pkg::status_t   status;

    modport source (
        output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, status,
        input  ready
    );

    modport sink (
        input  valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, status,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/cir_div.sv]
// ----------------------------------------------------------------------------
// cir_div
// Pipelined restoring divider, several lanes in lockstep, one quotient bit
// per stage, with a sideband word that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module cir_div #(
    parameter int LANES = 3,
    parameter int NW    = 63,
    parameter int DW    = 33,
    parameter int QW    = 33,
    parameter int SW    = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] dividend [LANES],
    input  wire logic [DW-1:0] divisor  [LANES],
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [QW-1:0]      quotient [LANES],
    output logic [SW-1:0]      side_out
);

    logic          valid_reg [0:QW];
    logic [SW-1:0] side_reg  [0:QW];
    logic [DW-1:0] rem_reg   [0:QW][LANES];
    logic [QW-1:0] low_reg   [0:QW][LANES];
    logic [QW-1:0] quot_reg  [0:QW][LANES];
    logic [DW-1:0] div_reg   [0:QW][LANES];

    assign valid_reg[0] = in_valid;
    assign side_reg[0]  = side_in;

    for (genvar l = 0; l < LANES; l++) begin : g_in
        assign rem_reg[0][l]  = DW'(dividend[l][NW-1:QW]);
        assign low_reg[0][l]  = dividend[l][QW-1:0];
        assign quot_reg[0][l] = '0;
        assign div_reg[0][l]  = divisor[l];
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end
            else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0]   trial;
            logic          qbit;
            logic [DW-1:0] rem_next;

            always_comb begin
                trial    = {rem_reg[k-1][l], low_reg[k-1][l][QW-1]};
                qbit     = trial >= {1'b0, div_reg[k-1][l]};
                rem_next = qbit ? DW'(trial - {1'b0, div_reg[k-1][l]}) : trial[DW-1:0];
            end

            always_ff @(posedge clk) begin
                if (en) begin
                    rem_reg[k][l]  <= rem_next;
                    low_reg[k][l]  <= {low_reg[k-1][l][QW-2:0], 1'b0};
                    quot_reg[k][l] <= {quot_reg[k-1][l][QW-2:0], qbit};
                    div_reg[k][l]  <= div_reg[k-1][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign side_out  = side_reg[QW];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign quotient[l] = quot_reg[QW][l];
    end

endmodule

`default_nettype wire

[hw/rtl/collision_impulse_resolve.sv]
// ----------------------------------------------------------------------------
// collision_impulse_resolve
// Impulse-based collision response for one pair of 2D bodies per transaction.
// ----------------------------------------------------------------------------
// Takes positions, velocities (signed Q16.16), masses (unsigned Q16.16) and
// elasticities (Q0.16) of two bodies and returns both velocities after the
// impulse along the line of centers, saturated to Q16.16, with a status of
// ok, coincident (velocities passed through) or saturated. One transaction
// is accepted every cycle while the output is not stalled; the projection
// and the mass weights are formed by the 33 one-bit stages of the divider.
// A stall on the output holds the whole pipeline.
`default_nettype none

module collision_impulse_resolve (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cir_in_if.sink     pair,
    cir_out_if.source  result
);

    localparam int QW = 33;

    logic en;

    // stage 1: differences, magnitudes, restitution, masses
    logic                s1_valid_reg;
    logic                s1_coin_reg, s1_dxneg_reg, s1_dyneg_reg;
    logic [32:0]         s1_ux_reg, s1_uy_reg;
    logic signed [32:0]  s1_rvx_reg, s1_rvy_reg;
    logic [17:0]         s1_q_reg;
    logic [31:0]         s1_ma_reg, s1_mb_reg;
    logic [32:0]         s1_msum_reg;
    cir_pkg::vel_t       s1_vel_reg;

    logic signed [32:0]  dx, dy;

    // stage 2: leading-one position
    logic                s2_valid_reg;
    logic                s2_coin_reg, s2_dxneg_reg, s2_dyneg_reg;
    logic [32:0]         s2_ux_reg, s2_uy_reg;
    logic [5:0]          s2_pos_reg;
    logic signed [32:0]  s2_rvx_reg, s2_rvy_reg;
    logic [17:0]         s2_q_reg;
    logic [31:0]         s2_ma_reg, s2_mb_reg;
    logic [32:0]         s2_msum_reg;
    cir_pkg::vel_t       s2_vel_reg;

    logic [32:0]         uor;
    logic [5:0]          pos_next;

    // stage 3: normalized direction
    logic                s3_valid_reg;
    logic                s3_coin_reg, s3_dxneg_reg, s3_dyneg_reg;
    logic [15:0]         s3_ux_reg, s3_uy_reg;
    logic signed [32:0]  s3_rvx_reg, s3_rvy_reg;
    logic [17:0]         s3_q_reg;
    logic [31:0]         s3_ma_reg, s3_mb_reg;
    logic [32:0]         s3_msum_reg;
    cir_pkg::vel_t       s3_vel_reg;

    logic                shr;
    logic [5:0]          amt;

    // stage 4: products
    logic                s4_valid_reg;
    logic                s4_coin_reg, s4_dxneg_reg, s4_dyneg_reg;
    logic [15:0]         s4_ux_reg, s4_uy_reg;
    logic signed [49:0]  s4_px_reg, s4_py_reg;
    logic [31:0]         s4_uxsq_reg, s4_uysq_reg;
    logic [17:0]         s4_q_reg;
    logic [31:0]         s4_ma_reg, s4_mb_reg;
    logic [32:0]         s4_msum_reg;
    cir_pkg::vel_t       s4_vel_reg;

    // stage 5: projection and squared length
    logic                s5_valid_reg;
    logic                s5_coin_reg, s5_dxneg_reg, s5_dyneg_reg;
    logic [15:0]         s5_ux_reg, s5_uy_reg;
    logic signed [50:0]  s5_p_reg;
    logic [32:0]         s5_dsum_reg;
    logic [17:0]         s5_q_reg;
    logic [31:0]         s5_ma_reg, s5_mb_reg;
    logic [32:0]         s5_msum_reg;
    cir_pkg::vel_t       s5_vel_reg;

    logic signed [50:0]  pxs, pys;
    logic [50:0]         pabs;

    // divider
    logic [62:0]         dv_dividend [3];
    logic [32:0]         dv_divisor  [3];
    logic [QW-1:0]       dv_quot     [3];
    cir_pkg::side_t      dv_side_in, dv_side_out;
    logic                dv_valid;

    // stage 7: projected velocity
    logic                s7_valid_reg;
    cir_pkg::side_t      s7_side_reg;
    logic [35:0]         s7_cx_reg, s7_cy_reg;
    logic [27:0]         s7_wa_reg, s7_wb_reg;
    logic [48:0]         gx, gy;

    // stage 8: restitution
    logic                s8_valid_reg;
    cir_pkg::side_t      s8_side_reg;
    logic [36:0]         s8_tx_reg, s8_ty_reg;
    logic [27:0]         s8_wa_reg, s8_wb_reg;
    logic [53:0]         ex, ey;

    // stage 9: mass weighting
    logic                s9_valid_reg;
    cir_pkg::side_t      s9_side_reg;
    logic [36:0]         s9_dax_reg, s9_day_reg, s9_dbx_reg, s9_dby_reg;
    logic [64:0]         max_, may_, mbx_, mby_;

    // output register
    logic                out_valid_reg;
    logic signed [31:0]  out_vax_reg, out_vay_reg, out_vbx_reg, out_vby_reg;
    cir_pkg::status_t    out_status_reg;

    logic                nax, nay;
    logic [32:0]         rax, ray, rbx, rby;

    assign en         = !out_valid_reg || result.ready;
    assign pair.ready = en;

    // ---------------- stage 1
    assign dx = 33'(pair.pos_b_x) - 33'(pair.pos_a_x);
    assign dy = 33'(pair.pos_b_y) - 33'(pair.pos_a_y);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (en) begin
            s1_valid_reg <= pair.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1_coin_reg  <= (dx == '0) && (dy == '0);
            s1_dxneg_reg <= dx[32];
            s1_dyneg_reg <= dy[32];
            s1_ux_reg    <= dx[32] ? 33'(-dx) : 33'(dx);
            s1_uy_reg    <= dy[32] ? 33'(-dy) : 33'(dy);
            s1_rvx_reg   <= 33'(pair.vel_b_x) - 33'(pair.vel_a_x);
            s1_rvy_reg   <= 33'(pair.vel_b_y) - 33'(pair.vel_a_y);
            s1_q_reg     <= 18'h20000 + {2'b00, pair.elast_a} + {2'b00, pair.elast_b};
            s1_ma_reg    <= (pair.mass_a == '0) ? 32'd1 : pair.mass_a;
            s1_mb_reg    <= (pair.mass_b == '0) ? 32'd1 : pair.mass_b;
            s1_msum_reg  <= {1'b0, (pair.mass_a == '0) ? 32'd1 : pair.mass_a}
                          + {1'b0, (pair.mass_b == '0) ? 32'd1 : pair.mass_b};
            s1_vel_reg   <= '{pair.vel_a_x, pair.vel_a_y, pair.vel_b_x, pair.vel_b_y};
        end
    end

    // ---------------- stage 2
    assign uor = s1_ux_reg | s1_uy_reg;

    always_comb begin
        pos_next = '0;
        for (int i = 0; i < 33; i++) begin
            if (uor[i]) begin
                pos_next = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end
        else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s2_coin_reg  <= s1_coin_reg;
            s2_dxneg_reg <= s1_dxneg_reg;
            s2_dyneg_reg <= s1_dyneg_reg;
            s2_ux_reg    <= s1_ux_reg;
            s2_uy_reg    <= s1_uy_reg;
            s2_pos_reg   <= pos_next;
            s2_rvx_reg   <= s1_rvx_reg;
            s2_rvy_reg   <= s1_rvy_reg;
            s2_q_reg     <= s1_q_reg;
            s2_ma_reg    <= s1_ma_reg;
            s2_mb_reg    <= s1_mb_reg;
            s2_msum_reg  <= s1_msum_reg;
            s2_vel_reg   <= s1_vel_reg;
        end
    end

    // ---------------- stage 3
    assign shr = s2_pos_reg >= 6'd15;
    assign amt = shr ? s2_pos_reg - 6'd15 : 6'd15 - s2_pos_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s3_valid_reg <= 1'b0;
        end
        else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s3_coin_reg  <= s2_coin_reg;
            s3_dxneg_reg <= s2_dxneg_reg;
            s3_dyneg_reg <= s2_dyneg_reg;
            s3_ux_reg    <= shr ? 16'(s2_ux_reg >> amt) : 16'(s2_ux_reg << amt);
            s3_uy_reg    <= shr ? 16'(s2_uy_reg >> amt) : 16'(s2_uy_reg << amt);
            s3_rvx_reg   <= s2_rvx_reg;
            s3_rvy_reg   <= s2_rvy_reg;
            s3_q_reg     <= s2_q_reg;
            s3_ma_reg    <= s2_ma_reg;
            s3_mb_reg    <= s2_mb_reg;
            s3_msum_reg  <= s2_msum_reg;
            s3_vel_reg   <= s2_vel_reg;
        end
    end

    // ---------------- stage 4
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s4_valid_reg <= 1'b0;
        end
        else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s4_coin_reg  <= s3_coin_reg;
            s4_dxneg_reg <= s3_dxneg_reg;
            s4_dyneg_reg <= s3_dyneg_reg;
            s4_ux_reg    <= s3_ux_reg;
            s4_uy_reg    <= s3_uy_reg;
            s4_px_reg    <= 50'(s3_rvx_reg * $signed({1'b0, s3_ux_reg}));
            s4_py_reg    <= 50'(s3_rvy_reg * $signed({1'b0, s3_uy_reg}));
            s4_uxsq_reg  <= s3_ux_reg * s3_ux_reg;
            s4_uysq_reg  <= s3_uy_reg * s3_uy_reg;
            s4_q_reg     <= s3_q_reg;
            s4_ma_reg    <= s3_ma_reg;
            s4_mb_reg    <= s3_mb_reg;
            s4_msum_reg  <= s3_msum_reg;
            s4_vel_reg   <= s3_vel_reg;
        end
    end

    // ---------------- stage 5
    assign pxs = s4_dxneg_reg ? -51'(s4_px_reg) : 51'(s4_px_reg);
    assign pys = s4_dyneg_reg ? -51'(s4_py_reg) : 51'(s4_py_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s5_valid_reg <= 1'b0;
        end
        else if (en) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s5_coin_reg  <= s4_coin_reg;
            s5_dxneg_reg <= s4_dxneg_reg;
            s5_dyneg_reg <= s4_dyneg_reg;
            s5_ux_reg    <= s4_ux_reg;
            s5_uy_reg    <= s4_uy_reg;
            s5_p_reg     <= pxs + pys;
            s5_dsum_reg  <= {1'b0, s4_uxsq_reg} + {1'b0, s4_uysq_reg};
            s5_q_reg     <= s4_q_reg;
            s5_ma_reg    <= s4_ma_reg;
            s5_mb_reg    <= s4_mb_reg;
            s5_msum_reg  <= s4_msum_reg;
            s5_vel_reg   <= s4_vel_reg;
        end
    end

    // ---------------- divider
    assign pabs = s5_p_reg[50] ? 51'(-s5_p_reg) : 51'(s5_p_reg);

    assign dv_dividend[0] = {pabs[49:0], 13'd0};
    assign dv_divisor[0]  = s5_dsum_reg;
    assign dv_dividend[1] = {3'd0, s5_mb_reg, 28'd0};
    assign dv_divisor[1]  = s5_msum_reg;
    assign dv_dividend[2] = {3'd0, s5_ma_reg, 28'd0};
    assign dv_divisor[2]  = s5_msum_reg;

    assign dv_side_in = '{
        coin:  s5_coin_reg,
        negp:  s5_p_reg[50],
        dxneg: s5_dxneg_reg,
        dyneg: s5_dyneg_reg,
        ux:    s5_ux_reg,
        uy:    s5_uy_reg,
        q:     s5_q_reg,
        vel:   s5_vel_reg
    };

    cir_div #(
        .LANES (3),
        .NW    (63),
        .DW    (33),
        .QW    (QW),
        .SW    ($bits(cir_pkg::side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .dividend  (dv_dividend),
        .divisor   (dv_divisor),
        .side_in   (dv_side_in),
        .out_valid (dv_valid),
        .quotient  (dv_quot),
        .side_out  (dv_side_out)
    );

    // ---------------- stage 7
    assign gx = dv_quot[0] * dv_side_out.ux;
    assign gy = dv_quot[0] * dv_side_out.uy;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s7_valid_reg <= 1'b0;
        end
        else if (en) begin
            s7_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s7_side_reg <= dv_side_out;
            s7_cx_reg   <= gx[48:cir_pkg::GSHIFT];
            s7_cy_reg   <= gy[48:cir_pkg::GSHIFT];
            s7_wa_reg   <= dv_quot[1][27:0];
            s7_wb_reg   <= dv_quot[2][27:0];
        end
    end

    // ---------------- stage 8
    assign ex = s7_cx_reg * s7_side_reg.q;
    assign ey = s7_cy_reg * s7_side_reg.q;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s8_valid_reg <= 1'b0;
        end
        else if (en) begin
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s8_side_reg <= s7_side_reg;
            s8_tx_reg   <= ex[53:cir_pkg::ESHIFT];
            s8_ty_reg   <= ey[53:cir_pkg::ESHIFT];
            s8_wa_reg   <= s7_wa_reg;
            s8_wb_reg   <= s7_wb_reg;
        end
    end

    // ---------------- stage 9
    assign max_ = s8_tx_reg * s8_wa_reg;
    assign may_ = s8_ty_reg * s8_wa_reg;
    assign mbx_ = s8_tx_reg * s8_wb_reg;
    assign mby_ = s8_ty_reg * s8_wb_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s9_valid_reg <= 1'b0;
        end
        else if (en) begin
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s9_side_reg <= s8_side_reg;
            s9_dax_reg  <= max_[64:cir_pkg::WSHIFT];
            s9_day_reg  <= may_[64:cir_pkg::WSHIFT];
            s9_dbx_reg  <= mbx_[64:cir_pkg::WSHIFT];
            s9_dby_reg  <= mby_[64:cir_pkg::WSHIFT];
        end
    end

    // ---------------- output register
    assign nax = s9_side_reg.negp ^ s9_side_reg.dxneg;
    assign nay = s9_side_reg.negp ^ s9_side_reg.dyneg;
    assign rax = cir_pkg::sat_apply(s9_side_reg.vel.vax, nax,  s9_dax_reg);
    assign ray = cir_pkg::sat_apply(s9_side_reg.vel.vay, nay,  s9_day_reg);
    assign rbx = cir_pkg::sat_apply(s9_side_reg.vel.vbx, !nax, s9_dbx_reg);
    assign rby = cir_pkg::sat_apply(s9_side_reg.vel.vby, !nay, s9_dby_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= s9_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            if (s9_side_reg.coin) begin
                out_vax_reg    <= s9_side_reg.vel.vax;
                out_vay_reg    <= s9_side_reg.vel.vay;
                out_vbx_reg    <= s9_side_reg.vel.vbx;
                out_vby_reg    <= s9_side_reg.vel.vby;
                out_status_reg <= cir_pkg::ST_COIN;
            end
            else begin
                out_vax_reg    <= rax[31:0];
                out_vay_reg    <= ray[31:0];
                out_vbx_reg    <= rbx[31:0];
                out_vby_reg    <= rby[31:0];
                out_status_reg <= (rax[32] || ray[32] || rbx[32] || rby[32])
                                  ? cir_pkg::ST_SAT : cir_pkg::ST_OK;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.new_vel_a_x = out_vax_reg;
    assign result.new_vel_a_y = out_vay_reg;
    assign result.new_vel_b_x = out_vbx_reg;
    assign result.new_vel_b_y = out_vby_reg;
    assign result.status      = out_status_reg;

`ifndef SYNTH
    logic at_limit;

    assign at_limit = out_vax_reg == 32'sh7fff_ffff || out_vax_reg == 32'sh8000_0000
                   || out_vay_reg == 32'sh7fff_ffff || out_vay_reg == 32'sh8000_0000
                   || out_vbx_reg == 32'sh7fff_ffff || out_vbx_reg == 32'sh8000_0000
                   || out_vby_reg == 32'sh7fff_ffff || out_vby_reg == 32'sh8000_0000;

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == cir_pkg::ST_SAT |-> at_limit)
        else $error("saturated status without a clamped velocity");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_status_reg == cir_pkg::ST_OK
                       || out_status_reg == cir_pkg::ST_COIN
                       || out_status_reg == cir_pkg::ST_SAT)
        else $error("undefined status code");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s9_valid_reg && !en |=> s9_valid_reg && $stable(s9_dax_reg))
        else $error("pipeline lost a transaction during a stall");
`endif

endmodule

`default_nettype wire
